// File: hdl/ptmf_pkg.sv
// Shared types and constants of the profile table mask filter.
`default_nettype none
package ptmf_pkg;

	localparam int ID_COUNT = 64;
	localparam int ID_W = $clog2(ID_COUNT);
	localparam int CNT_W = $clog2(ID_COUNT + 1);
	localparam int RID_W = 9;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_RANGE    = 3'd2,
		ST_MATCH    = 3'd3,
		ST_NOMATCH  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INSERT,
		BK_SCAN,
		BK_FINISH
	} bk_state_t;

	// classified request as it travels from the front to the back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  id;
		logic        id_bad;
		logic [31:0] flags;
		logic [7:0]  t_mask;
		logic [7:0]  n_mask;
		logic [7:0]  a_mask;
		logic [7:0]  c_mask;
		logic        pass_all;
		logic        pass_none;
		logic        t_any;
		logic        n_any;
		logic        a_any;
		logic        c_any;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// File: hdl/ptmf_channels.sv
// Request and result channel interfaces of the profile table mask filter.
`default_nettype none
interface ptmf_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  profile_id;
	logic [7:0]  transport_flags;
	logic [7:0]  network_flags;
	logic [7:0]  access_flags;
	logic [7:0]  channel_flags;
	logic [31:0] filter_word;

	modport source (
		output valid, cmd, profile_id, transport_flags, network_flags,
			access_flags, channel_flags, filter_word,
		input ready
	);
	modport sink (
		input valid, cmd, profile_id, transport_flags, network_flags,
			access_flags, channel_flags, filter_word,
		output ready
	);
endinterface

interface ptmf_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [5:0] match_id;
	logic [7:0] match_transport;
	logic [7:0] match_network;
	logic [7:0] match_access;
	logic [7:0] match_channel;
	logic [6:0] profile_count;
	logic       last;

	modport source (
		output valid, status, match_id, match_transport, match_network,
			match_access, match_channel, profile_count, last,
		input ready
	);
	modport sink (
		input valid, status, match_id, match_transport, match_network,
			match_access, match_channel, profile_count, last,
		output ready
	);
endinterface
`default_nettype wire

// File: hdl/ptmf_front.sv
// Front end: accepts requests, classifies them and hands them to the queue.
`default_nettype none
module ptmf_front
	import ptmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ptmf_req_if.sink   req,
	input  q_stat_t    q_stat,
	output logic       push,
	output cmd_t       push_cmd
);

	logic hold_q;
	cmd_t cmd_s1;
	cmd_t cmd_d;
	logic take;

	assign req.ready = !hold_q || !q_stat.full;
	assign take = req.valid && req.ready;
	assign push = hold_q && !q_stat.full;
	assign push_cmd = cmd_s1;

	always_comb begin
		cmd_d.kind = req.cmd ? CMD_QUERY : CMD_INSERT;
		cmd_d.id = req.profile_id;
		cmd_d.id_bad = {1'b0, req.profile_id} >= RID_W'(ID_COUNT);
		cmd_d.flags = {req.transport_flags, req.network_flags,
			req.access_flags, req.channel_flags};
		cmd_d.t_mask = req.filter_word[31:24];
		cmd_d.n_mask = req.filter_word[23:16];
		cmd_d.a_mask = req.filter_word[15:8];
		cmd_d.c_mask = req.filter_word[7:0];
		cmd_d.pass_all = &req.filter_word;
		cmd_d.pass_none = req.filter_word == 32'h0;
		cmd_d.t_any = &req.filter_word[31:24];
		cmd_d.n_any = &req.filter_word[23:16];
		cmd_d.a_any = &req.filter_word[15:8];
		cmd_d.c_any = &req.filter_word[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else begin
			hold_q <= take || (hold_q && q_stat.full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptmf_cmd_fifo.sv
// Short request queue between the front and back ends.
`default_nettype none
module ptmf_cmd_fifo
	import ptmf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output q_stat_t q_stat,
	output cmd_t    head
);

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full = cnt_q == QCNT_W'(QDEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign head = ent_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ptmf_back.sv
// Back end: profile table, insert handling, query scan and result register.
`default_nettype none
module ptmf_back
	import ptmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  cmd_t      head,
	output logic      pop,
	ptmf_rsp_if.source rsp
);

	typedef struct packed {
		status_t    status;
		logic [5:0] id;
		logic [31:0] flags;
		logic [6:0] count;
		logic       last;
	} rsp_t;

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [ID_COUNT-1:0] valid_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       mem [ID_COUNT];

	logic [ID_W-1:0]   issue_idx_q;
	logic              issue_left_q;
	logic              vld_s1;
	logic              ent_vld_s1;
	logic [ID_W-1:0]   idx_s1;
	logic [31:0]       flags_s1;

	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_idx_q;
	logic [31:0]       pend_flags_q;

	logic              out_vld_q;
	rsp_t              out_q;

	logic              slot_free;
	logic              match_s1;
	logic              consume;
	logic              issue;
	logic              pend_load;
	logic              scan_start;
	logic              ins_wr;
	logic              emit;
	rsp_t              emit_rsp;
	logic [CNT_W-1:0]  cnt_next;

	function automatic logic prof_match(input logic [31:0] f, input cmd_t c);
		logic t_ok;
		logic n_ok;
		logic a_ok;
		logic ch_ok;
		t_ok = c.t_any || ((f[31:24] & ~c.t_mask) == 8'h00);
		n_ok = c.n_any || ((f[23:16] & ~c.n_mask) == 8'h00);
		a_ok = c.a_any || ((f[15:8] & ~c.a_mask) == 8'h00);
		// channel check needs the channel-info bit of the access byte
		ch_ok = c.c_any || (f[8] && ((f[7:0] & ~c.c_mask) == 8'h00));
		return c.pass_all || (!c.pass_none && t_ok && n_ok && a_ok && ch_ok);
	endfunction

	assign slot_free = !out_vld_q || rsp.ready;
	assign match_s1 = vld_s1 && ent_vld_s1 && prof_match(flags_s1, head);
	assign cnt_next = count_q + CNT_W'(ins_wr);

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		emit = 1'b0;
		emit_rsp = '0;
		ins_wr = 1'b0;
		scan_start = 1'b0;
		issue = 1'b0;
		consume = 1'b1;
		pend_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					if (head.kind == CMD_QUERY) begin
						state_d = BK_SCAN;
						scan_start = 1'b1;
					end else begin
						state_d = BK_INSERT;
					end
				end
			end
			BK_INSERT: begin
				if (slot_free) begin
					emit = 1'b1;
					pop = 1'b1;
					state_d = BK_IDLE;
					if (head.id_bad) begin
						emit_rsp.status = ST_RANGE;
					end else if (valid_q[head.id[ID_W-1:0]]) begin
						emit_rsp.status = ST_PRESENT;
					end else begin
						emit_rsp.status = ST_INSERTED;
						ins_wr = 1'b1;
					end
					emit_rsp.count = 7'(cnt_next);
					emit_rsp.last = 1'b1;
				end
			end
			BK_SCAN: begin
				// a held match goes out only once a later match proves it is not last
				consume = !match_s1 || !pend_vld_q || slot_free;
				if (match_s1 && pend_vld_q && slot_free) begin
					emit = 1'b1;
					emit_rsp.status = ST_MATCH;
					emit_rsp.id = 6'(pend_idx_q);
					emit_rsp.flags = pend_flags_q;
					emit_rsp.count = 7'(count_q);
					emit_rsp.last = 1'b0;
				end
				pend_load = match_s1 && consume;
				issue = issue_left_q && consume;
				if (!issue_left_q && !vld_s1) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (slot_free) begin
					emit = 1'b1;
					pop = 1'b1;
					state_d = BK_IDLE;
					emit_rsp.count = 7'(count_q);
					emit_rsp.last = 1'b1;
					if (pend_vld_q) begin
						emit_rsp.status = ST_MATCH;
						emit_rsp.id = 6'(pend_idx_q);
						emit_rsp.flags = pend_flags_q;
					end else begin
						emit_rsp.status = ST_NOMATCH;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			count_q <= '0;
			issue_idx_q <= '0;
			issue_left_q <= 1'b0;
			vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_wr) begin
				valid_q[head.id[ID_W-1:0]] <= 1'b1;
				count_q <= cnt_next;
			end
			if (scan_start) begin
				issue_idx_q <= '0;
				issue_left_q <= 1'b1;
				vld_s1 <= 1'b0;
				pend_vld_q <= 1'b0;
			end else begin
				if (issue) begin
					issue_idx_q <= issue_idx_q + ID_W'(1);
					if (issue_idx_q == ID_W'(ID_COUNT - 1)) begin
						issue_left_q <= 1'b0;
					end
					vld_s1 <= 1'b1;
				end else if (consume) begin
					vld_s1 <= 1'b0;
				end
				if (pend_load) begin
					pend_vld_q <= 1'b1;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// table memory: one write port for inserts, one registered read for the scan
	always_ff @(posedge clk) begin
		if (ins_wr) begin
			mem[head.id[ID_W-1:0]] <= head.flags;
		end
		if (issue) begin
			flags_s1 <= mem[issue_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= issue_idx_q;
			ent_vld_s1 <= valid_q[issue_idx_q];
		end
		if (pend_load) begin
			pend_idx_q <= idx_s1;
			pend_flags_q <= flags_s1;
		end
		if (emit) begin
			out_q <= emit_rsp;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_q.status;
	assign rsp.match_id = out_q.id;
	assign rsp.match_transport = out_q.flags[31:24];
	assign rsp.match_network = out_q.flags[23:16];
	assign rsp.match_access = out_q.flags[15:8];
	assign rsp.match_channel = out_q.flags[7:0];
	assign rsp.profile_count = out_q.count;
	assign rsp.last = out_q.last;

endmodule
`default_nettype wire

// File: hdl/profile_table_mask_filter_core.sv
// Top level of the profile table mask filter.
// Requests come in on req (valid/ready): cmd 0 inserts a profile of four
// flag bytes under profile_id, cmd 1 queries the table with filter_word.
// Results leave on rsp (valid/ready); every request produces one or more
// results and the final one carries last.
// An insert passes through the front register, the queue and the back end's
// insert state before its result is registered. A query walks the table one
// entry per cycle through the table memory read port, except while the scan
// pauses on a held match for the receiver.
// Requests are executed one at a time; the front register and a
// two-entry queue keep taking requests while a query runs.
// A match is held back until the next match or the end of the scan, so its
// last flag is known when it leaves.
// When rsp.ready is low the result register holds and the scan pauses at the
// next match; the queue then fills and req.ready drops.
// Reset empties the table (valid bits and count cleared at once); the table
// contents are undefined until written, but entries without a valid bit never match.
`default_nettype none
module profile_table_mask_filter_core
	import ptmf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ptmf_req_if.sink   req,
	ptmf_rsp_if.source rsp
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head;

	ptmf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ptmf_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.q_stat   (q_stat),
		.head     (head)
	);

	ptmf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("request pushed into a full queue");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> rsp.valid && rsp.last)
		else $error("request retired without a final result");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_NOMATCH || rsp.status == ST_INSERTED ||
			rsp.status == ST_PRESENT || rsp.status == ST_RANGE)
		|-> rsp.last && rsp.match_id == 6'd0)
		else $error("single result not marked last or carries an id");

endmodule
`default_nettype wire
